@@ rtl/core/mrcs_pkg.sv @@
// Shared types and constants for the multi-frame reassembly checksum unit.
// No dependencies; every other file in rtl/core except mrcs_ram imports this package.
package mrcs_pkg;

	localparam int STORE_BYTES = 256;
	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int IDX_W = ADDR_W + 1;
	localparam int POS_W = 9;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int FRAME_BYTES = 8;
	localparam int FIRST_BYTES = 6;

	localparam logic [1:0] FLAG_MIDDLE = 2'h2;
	localparam logic [1:0] FLAG_LAST = 2'h3;

	localparam logic [1:0] OP_FIRST = 2'd0;
	localparam logic [1:0] OP_MIDDLE = 2'd1;
	localparam logic [1:0] OP_LAST = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [POS_W-1:0] base_pos;
		logic base_ok;
		logic [3:0] nbytes;
		logic [FRAME_BYTES-1:0][7:0] data;
		logic [7:0] got;
	} mrcs_task_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mrcs_qstat_t;

endpackage

@@ rtl/core/mrcs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mrcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/mrcs_front.sv @@
// Front end: accepts frames, decodes their position code and builds a work entry.
// Depends on mrcs_pkg.
module mrcs_front
	import mrcs_pkg::*;
(
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] frame_flag,
	input logic [5:0] frame_count,
	input logic [3:0] data_length,
	input logic [FRAME_BYTES-1:0][7:0] data,
	input mrcs_qstat_t q_stat,
	input logic clearing,
	output logic q_push,
	output mrcs_task_t q_entry
);

	logic [3:0] dlc_c;
	logic [2:0] got_idx;
	logic keep;

	always_comb begin
		dlc_c = (data_length > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : data_length;
		got_idx = 3'(dlc_c - 4'd1);
		keep = 1'b0;
		q_entry.data = data;
		q_entry.got = data[got_idx];
		q_entry.base_pos = {6'(frame_count - 6'd1), 3'd0};
		q_entry.base_ok = (frame_count != 6'd0);
		q_entry.op = OP_MIDDLE;
		q_entry.nbytes = 4'(FRAME_BYTES);
		unique case (frame_flag)
			FLAG_MIDDLE: begin
				keep = 1'b1;
			end
			FLAG_LAST: begin
				// A last frame without any data byte carries no checksum.
				keep = (dlc_c != 4'd0);
				q_entry.op = OP_LAST;
				q_entry.nbytes = dlc_c - 4'd1;
			end
			default: begin
				keep = (frame_count == 6'd1);
				q_entry.op = OP_FIRST;
				q_entry.nbytes = 4'(FIRST_BYTES);
				q_entry.base_pos = '0;
				q_entry.base_ok = 1'b1;
			end
		endcase
	end

	assign in_stall = clearing || q_stat.full;
	assign q_push = in_valid && !in_stall && keep;

endmodule

@@ rtl/core/mrcs_queue.sv @@
// Short FIFO of decoded work entries between the front end and the back end.
// Depends on mrcs_pkg.
module mrcs_queue
	import mrcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input mrcs_task_t push_entry,
	input logic pop,
	output mrcs_task_t head,
	output mrcs_qstat_t stat
);

	mrcs_task_t slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_next(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_next(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head = slot_q[rptr_q];
	assign stat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

@@ rtl/core/mrcs_back.sv @@
// Back end: clears the byte store after reset, writes frame bytes one per cycle
// and sums the message for a last frame. Depends on mrcs_pkg and mrcs_ram.
module mrcs_back
	import mrcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input mrcs_task_t head,
	input mrcs_qstat_t q_stat,
	output logic pop,
	output logic clearing,
	output logic out_valid,
	input logic out_stall,
	output logic sum_matches,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_SUM = 2'd3;

	logic [1:0] state_q;
	mrcs_task_t cur_q;
	logic [3:0] wr_idx_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] lim_q;
	logic [7:0] sum_q;
	logic rd_pend_q;
	logic [15:0] len_q;
	logic out_valid_q;
	logic [7:0] out_sum_q;
	logic [7:0] out_got_q;

	logic [POS_W-1:0] pos;
	logic wr_more;
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic ram_re;
	logic [7:0] ram_rdata;
	logic [7:0] sum_n;
	logic [IDX_W-1:0] lim_n;
	logic finish;

	mrcs_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		pos = cur_q.base_pos + POS_W'(wr_idx_q);
		wr_more = (wr_idx_q < cur_q.nbytes);
		// The sum covers (length + 1) mod 256 bytes, never beyond the store.
		sum_n = len_q[7:0] + 8'd1;
		if (32'(sum_n) < STORE_BYTES) begin
			lim_n = IDX_W'(sum_n);
		end else begin
			lim_n = IDX_W'(STORE_BYTES);
		end
		ram_we = 1'b0;
		ram_waddr = ADDR_W'(pos);
		ram_wdata = cur_q.data[wr_idx_q[2:0]];
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = idx_q[ADDR_W-1:0];
			ram_wdata = '0;
		end else if (state_q == ST_WRITE) begin
			ram_we = wr_more && cur_q.base_ok && (32'(pos) < STORE_BYTES);
		end
		ram_re = (state_q == ST_SUM) && (idx_q < lim_q);
		finish = (state_q == ST_SUM) && !ram_re && !rd_pend_q
			&& (!out_valid_q || !out_stall);
	end

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;
	assign clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (finish) begin
			out_sum_q <= sum_q;
			out_got_q <= cur_q.got;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wr_idx_q <= '0;
			idx_q <= '0;
			lim_q <= '0;
			sum_q <= '0;
			rd_pend_q <= 1'b0;
			len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == IDX_W'(STORE_BYTES - 1)) begin
						idx_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						wr_idx_q <= '0;
						if (head.op == OP_FIRST) begin
							len_q <= {head.data[0], head.data[1]};
						end
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wr_more) begin
						wr_idx_q <= wr_idx_q + 1'b1;
					end else if (cur_q.op == OP_LAST) begin
						idx_q <= '0;
						lim_q <= lim_n;
						sum_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					if (ram_re) begin
						idx_q <= idx_q + 1'b1;
					end
					rd_pend_q <= ram_re;
					if (rd_pend_q) begin
						sum_q <= sum_q + ram_rdata;
					end
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign computed_sum = out_sum_q;
	assign received_sum = out_got_q;
	assign sum_matches = (out_sum_q == out_got_q);

`ifndef SYNTHESIS
	a_no_write_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> !ram_we)
		else $error("store written during checksum pass");
	a_read_pending_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> $past(state_q) == ST_SUM)
		else $error("read data pending outside checksum pass");
	a_result_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_SUM)
		else $error("result raised outside checksum pass");
	a_idx_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (idx_q <= lim_q))
		else $error("checksum index ran past its limit");
`endif

endmodule

@@ rtl/core/multiframe_reassembly_checksum_unit.sv @@
// Multi-frame reassembly checksum unit, top level.
// Depends on mrcs_pkg, mrcs_front, mrcs_queue and mrcs_back.
//
// The input channel (in_valid / in_stall) carries one received CAN frame per
// transaction. First frames latch the message length and store bytes 0 to 5,
// middle frames store eight bytes, last frames store their data bytes except
// the final one, which is the received checksum. The output channel
// (out_valid / out_stall) carries one transaction per last frame with a
// nonzero data length: the modulo-256 sum of the first (length + 1) mod 256
// stored bytes, the received byte and a match flag.
// After reset the byte store is cleared one byte per cycle, with in_stall held
// high. A frame then waits in a two-entry queue. The back end takes it from
// the queue, writes its stored bytes one per cycle and, for a last frame, does
// one store read per summed byte (up to 255) and adds each read byte to the
// sum; the single store port paces these steps.
// A finished result waits in the output register while out_stall is high; the
// back end holds the next last frame until that register is free.
module multiframe_reassembly_checksum_unit
	import mrcs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] frame_flag,
	input logic [5:0] frame_count,
	input logic [3:0] data_length,
	input logic [7:0] byte_0,
	input logic [7:0] byte_1,
	input logic [7:0] byte_2,
	input logic [7:0] byte_3,
	input logic [7:0] byte_4,
	input logic [7:0] byte_5,
	input logic [7:0] byte_6,
	input logic [7:0] byte_7,
	output logic out_valid,
	input logic out_stall,
	output logic sum_matches,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum
);

	logic [FRAME_BYTES-1:0][7:0] data;
	mrcs_qstat_t q_stat;
	mrcs_task_t q_entry;
	mrcs_task_t q_head;
	logic q_push;
	logic q_pop;
	logic clearing;

	assign data = {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};

	mrcs_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_flag(frame_flag),
		.frame_count(frame_count),
		.data_length(data_length),
		.data(data),
		.q_stat(q_stat),
		.clearing(clearing),
		.q_push(q_push),
		.q_entry(q_entry)
	);

	mrcs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(q_entry),
		.pop(q_pop),
		.head(q_head),
		.stat(q_stat)
	);

	mrcs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.q_stat(q_stat),
		.pop(q_pop),
		.clearing(clearing),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_matches(sum_matches),
		.computed_sum(computed_sum),
		.received_sum(received_sum)
	);

endmodule
